// ===== rtl/lz4_block_decompressor_unit_defines.svh =====
// assertion macros for the lz4 block decompressor unit
// used by the modules that carry concurrent checks; no other dependency
`ifndef LZ4_BLOCK_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_UNIT_DEFINES_SVH

// same-cycle implication under synchronous reset
`define LZ4BD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define LZ4BD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lz4bd_pkg.sv =====
// shared types and constants of the lz4 block decompressor
// no dependencies; used by every other rtl file but the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

package lz4bd_pkg;

   localparam int HIST_DEPTH = 65536;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int RSP_DEPTH  = 3;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   localparam logic [3:0]        NIBBLE_EXT = 4'hf;
   localparam logic [7:0]        BYTE_EXT   = 8'hff;
   localparam logic [LEN_W-1:0]  MATCH_MIN  = 16'd4;

   typedef enum logic {
      CMD_PUSH    = 1'b0,
      CMD_ADVANCE = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DATA        = 2'd0,
      ST_LAST        = 2'd1,
      ST_ZERO_OFFSET = 2'd2,
      ST_OVERRUN     = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      PH_TOKEN    = 8'b0000_0001,
      PH_LITLEN   = 8'b0000_0010,
      PH_LITERALS = 8'b0000_0100,
      PH_OFFLO    = 8'b0000_1000,
      PH_OFFHI    = 8'b0001_0000,
      PH_MATCHLEN = 8'b0010_0000,
      PH_COPY     = 8'b0100_0000,
      PH_DONE     = 8'b1000_0000
   } phase_type;

   // decoder to history stage: one result in flight
   typedef struct packed {
      logic                valid;
      logic                store;
      logic                from_hist;
      logic [HIST_AW-1:0]  raddr;
      logic [HIST_AW-1:0]  waddr;
      logic [BYTE_W-1:0]   lit_byte;
      status_type          status;
   } issue_type;

   // history stage to response queue
   typedef struct packed {
      logic                valid;
      logic [BYTE_W-1:0]   out_byte;
      status_type          status;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/lz4bd_req_if.sv =====
// request channel: command and compressed byte with valid/ready
// depends on lz4bd_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

interface lz4bd_req_if;
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic [lz4bd_pkg::BYTE_W-1:0]      in_byte;

   modport source (output valid, output command, output in_byte, input ready);
   modport sink   (input valid, input command, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/lz4bd_rsp_if.sv =====
// response channel: decompressed byte and status with valid/ready
// depends on lz4bd_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

interface lz4bd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lz4bd_pkg::BYTE_W-1:0]      out_byte;
   logic [lz4bd_pkg::STATUS_W-1:0]    status;

   modport source (output valid, output out_byte, output status, input ready);
   modport sink   (input valid, input out_byte, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/lz4_block_decompressor_unit.sv =====
// LZ4 block decompressor, top level: decoder, history stage and response queue
// depends on lz4bd_pkg, lz4bd_req_if, lz4bd_rsp_if, lz4bd_seq, lz4bd_hist, lz4bd_rsp_fifo
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per cycle while ready is high: a push delivers one
// compressed byte of the block (token, length bytes, literals, offset), an
// advance emits one pending match byte. Lengths and the block state live in
// the decoder registers; the 64K byte history is one synchronous memory with
// one write and one read port; a literal or copied byte passes the history
// stage register and the response queue, and a copy that reads the byte written
// just before it is served by forwarding. A three-entry response queue lets
// requests keep flowing at one per cycle; ready drops only when three results
// are in flight. The history needs no clearing after reset. Writing the block
// length restarts the decoder and keeps history and write position.

module lz4_block_decompressor_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   lz4bd_req_if.sink                           req_bus,
   lz4bd_rsp_if.source                         rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [lz4bd_pkg::LEN_W-1:0]    csr_wr_data
);

   lz4bd_pkg::issue_type                    issue;
   lz4bd_pkg::rsp_item_type                 push;
   logic [lz4bd_pkg::RSP_CNT_W-1:0]         q_count;
   logic [lz4bd_pkg::RSP_CNT_W:0]           in_flight;
   logic                                    accept;

   localparam logic [lz4bd_pkg::RSP_CNT_W:0] RoomLimit =
      (lz4bd_pkg::RSP_CNT_W + 1)'(lz4bd_pkg::RSP_DEPTH - 1);

   // results queued plus the one in the history stage
   assign in_flight     = {1'b0, q_count} + {{lz4bd_pkg::RSP_CNT_W{1'b0}}, push.valid};
   assign req_bus.ready = (in_flight <= RoomLimit);
   assign accept        = req_bus.valid && req_bus.ready;

   lz4bd_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .command     (req_bus.command),
      .in_byte     (req_bus.in_byte),
      .issue       (issue)
   );

   lz4bd_hist u_hist (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .push  (push)
   );

   lz4bd_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .count   (q_count),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== rtl/lz4bd_seq.sv =====
// sequence decoder: token, lengths, offset and copy bookkeeping per request
// depends on lz4bd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "lz4_block_decompressor_unit_defines.svh"

module lz4bd_seq (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [lz4bd_pkg::LEN_W-1:0]         csr_wr_data,
   input  wire logic                                accept,
   input  wire logic                                command,
   input  wire logic [lz4bd_pkg::BYTE_W-1:0]        in_byte,
   output lz4bd_pkg::issue_type                     issue
);

   lz4bd_pkg::phase_type                    phase_ff, phase_in;
   logic [lz4bd_pkg::LEN_W-1:0]             bsize_ff, bsize_in;
   logic [lz4bd_pkg::LEN_W-1:0]             consumed_ff, consumed_in;
   logic [lz4bd_pkg::LEN_W-1:0]             lit_left_ff, lit_left_in;
   logic [lz4bd_pkg::LEN_W-1:0]             match_left_ff, match_left_in;
   logic [3:0]                              nibble_ff, nibble_in;
   logic [lz4bd_pkg::LEN_W-1:0]             dist_ff, dist_in;
   logic [lz4bd_pkg::HIST_AW-1:0]           wp_ff, wp_in;

   logic                                    active;
   logic                                    end_old;
   logic                                    end_new;
   logic [lz4bd_pkg::LEN_W-1:0]             cons_inc;
   logic [lz4bd_pkg::LEN_W-1:0]             lit_sum;
   logic [lz4bd_pkg::LEN_W-1:0]             lit_dec;
   logic [lz4bd_pkg::LEN_W-1:0]             match_dec;
   logic [lz4bd_pkg::LEN_W-1:0]             match_sum;
   logic [lz4bd_pkg::LEN_W-1:0]             match_sum4;
   logic [lz4bd_pkg::LEN_W-1:0]             token_lit;
   logic [lz4bd_pkg::LEN_W-1:0]             offset_full;

   assign active      = accept && (bsize_ff != '0) && (phase_ff != lz4bd_pkg::PH_DONE);
   assign end_old     = (consumed_ff == bsize_ff);
   assign cons_inc    = consumed_ff + 16'd1;
   assign end_new     = (cons_inc == bsize_ff);
   assign token_lit   = {12'd0, in_byte[7:4]};
   assign lit_sum     = lit_left_ff + {8'd0, in_byte};
   assign lit_dec     = lit_left_ff - 16'd1;
   assign match_dec   = match_left_ff - 16'd1;
   assign match_sum   = match_left_ff + {8'd0, in_byte};
   assign match_sum4  = match_sum + lz4bd_pkg::MATCH_MIN;
   assign offset_full = {in_byte, dist_ff[7:0]};

   always_comb begin
      phase_in      = phase_ff;
      bsize_in      = bsize_ff;
      consumed_in   = consumed_ff;
      lit_left_in   = lit_left_ff;
      match_left_in = match_left_ff;
      nibble_in     = nibble_ff;
      dist_in       = dist_ff;
      wp_in         = wp_ff;

      issue           = '0;
      issue.raddr     = wp_ff - dist_ff[lz4bd_pkg::HIST_AW-1:0];
      issue.waddr     = wp_ff;
      issue.lit_byte  = in_byte;
      issue.status    = lz4bd_pkg::ST_DATA;

      if (csr_wr_en) begin
         bsize_in      = csr_wr_data;
         phase_in      = lz4bd_pkg::PH_TOKEN;
         consumed_in   = '0;
         lit_left_in   = '0;
         match_left_in = '0;
         nibble_in     = '0;
         dist_in       = '0;
      end else if (active) begin
         if (command == lz4bd_pkg::CMD_ADVANCE) begin
            if (phase_ff == lz4bd_pkg::PH_COPY) begin
               issue.valid     = 1'b1;
               issue.store     = 1'b1;
               issue.from_hist = 1'b1;
               wp_in           = wp_ff + 1'b1;
               match_left_in   = match_dec;
               if (match_dec == '0) begin
                  if (end_old) begin
                     issue.status = lz4bd_pkg::ST_LAST;
                     phase_in     = lz4bd_pkg::PH_DONE;
                  end else begin
                     phase_in     = lz4bd_pkg::PH_TOKEN;
                  end
               end
            end
         end else if (phase_ff != lz4bd_pkg::PH_COPY) begin
            if (end_old) begin
               // byte beyond the block size
               issue.valid    = 1'b1;
               issue.lit_byte = '0;
               issue.status   = lz4bd_pkg::ST_OVERRUN;
               phase_in       = lz4bd_pkg::PH_DONE;
            end else begin
               consumed_in = cons_inc;
               unique case (phase_ff)
                  lz4bd_pkg::PH_TOKEN: begin
                     nibble_in   = in_byte[3:0];
                     lit_left_in = token_lit;
                     if (in_byte[7:4] == lz4bd_pkg::NIBBLE_EXT) begin
                        phase_in = lz4bd_pkg::PH_LITLEN;
                     end else if (token_lit != '0) begin
                        phase_in = lz4bd_pkg::PH_LITERALS;
                     end else begin
                        phase_in = end_new ? lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_OFFLO;
                     end
                  end
                  lz4bd_pkg::PH_LITLEN: begin
                     lit_left_in = lit_sum;
                     if (in_byte != lz4bd_pkg::BYTE_EXT) begin
                        if (lit_sum != '0) begin
                           phase_in = lz4bd_pkg::PH_LITERALS;
                        end else begin
                           phase_in = end_new ? lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_OFFLO;
                        end
                     end
                  end
                  lz4bd_pkg::PH_LITERALS: begin
                     issue.valid = 1'b1;
                     issue.store = 1'b1;
                     wp_in       = wp_ff + 1'b1;
                     lit_left_in = lit_dec;
                     if (lit_dec == '0) begin
                        if (end_new) begin
                           issue.status = lz4bd_pkg::ST_LAST;
                           phase_in     = lz4bd_pkg::PH_DONE;
                        end else begin
                           phase_in     = lz4bd_pkg::PH_OFFLO;
                        end
                     end
                  end
                  lz4bd_pkg::PH_OFFLO: begin
                     dist_in  = {8'd0, in_byte};
                     phase_in = lz4bd_pkg::PH_OFFHI;
                  end
                  lz4bd_pkg::PH_OFFHI: begin
                     dist_in = offset_full;
                     if (offset_full == '0) begin
                        issue.valid    = 1'b1;
                        issue.lit_byte = '0;
                        issue.status   = lz4bd_pkg::ST_ZERO_OFFSET;
                        phase_in       = lz4bd_pkg::PH_DONE;
                     end else if (nibble_ff == lz4bd_pkg::NIBBLE_EXT) begin
                        match_left_in = {12'd0, lz4bd_pkg::NIBBLE_EXT};
                        phase_in      = lz4bd_pkg::PH_MATCHLEN;
                     end else begin
                        // short match is never empty
                        match_left_in = {12'd0, nibble_ff} + lz4bd_pkg::MATCH_MIN;
                        phase_in      = lz4bd_pkg::PH_COPY;
                     end
                  end
                  lz4bd_pkg::PH_MATCHLEN: begin
                     if (in_byte != lz4bd_pkg::BYTE_EXT) begin
                        match_left_in = match_sum4;
                        if (match_sum4 != '0) begin
                           phase_in = lz4bd_pkg::PH_COPY;
                        end else begin
                           phase_in = end_new ? lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_TOKEN;
                        end
                     end else begin
                        match_left_in = match_sum;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= lz4bd_pkg::PH_TOKEN;
         bsize_ff      <= '0;
         consumed_ff   <= '0;
         lit_left_ff   <= '0;
         match_left_ff <= '0;
         nibble_ff     <= '0;
         dist_ff       <= '0;
         wp_ff         <= '0;
      end else begin
         phase_ff      <= phase_in;
         bsize_ff      <= bsize_in;
         consumed_ff   <= consumed_in;
         lit_left_ff   <= lit_left_in;
         match_left_ff <= match_left_in;
         nibble_ff     <= nibble_in;
         dist_ff       <= dist_in;
         wp_ff         <= wp_in;
      end
   end

   `LZ4BD_ASSERT_IMP(a_copy_has_bytes, clock, reset, phase_ff == lz4bd_pkg::PH_COPY, match_left_ff != '0, "copy phase with no pending match byte")
   `LZ4BD_ASSERT_IMP(a_result_needs_accept, clock, reset, issue.valid, accept && (bsize_ff != '0), "result issued without an accepted request")
   `LZ4BD_ASSERT_IMP(a_advance_only_in_copy, clock, reset, accept && (command == lz4bd_pkg::CMD_ADVANCE) && (phase_ff != lz4bd_pkg::PH_COPY), !issue.valid, "advance outside copy produced a result")

endmodule

`default_nettype wire

// ===== rtl/lz4bd_hist.sv =====
// history memory stage: synchronous 64k byte store, copy read and write-back
// depends on lz4bd_pkg; fed by lz4bd_seq, feeds lz4bd_rsp_fifo
`timescale 1ns / 1ps
`default_nettype none

module lz4bd_hist (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  lz4bd_pkg::issue_type          issue,
   output lz4bd_pkg::rsp_item_type       push
);

   logic [lz4bd_pkg::BYTE_W-1:0]    mem [lz4bd_pkg::HIST_DEPTH];

   lz4bd_pkg::issue_type            s1_ff;
   logic                            s1_valid_ff;
   logic [lz4bd_pkg::BYTE_W-1:0]    rdata_ff;
   logic                            last_we_ff;
   logic [lz4bd_pkg::HIST_AW-1:0]   last_wa_ff;
   logic [lz4bd_pkg::BYTE_W-1:0]    last_wd_ff;

   logic                            fwd_hit;
   logic                            wr_en;
   logic [lz4bd_pkg::BYTE_W-1:0]    s1_data;

   // the read issued last cycle missed the write done in that same cycle
   assign fwd_hit = last_we_ff && (last_wa_ff == s1_ff.raddr);
   assign s1_data = s1_ff.from_hist ? (fwd_hit ? last_wd_ff : rdata_ff) : s1_ff.lit_byte;
   assign wr_en   = s1_valid_ff && s1_ff.store;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[issue.raddr];
      if (wr_en) begin
         mem[s1_ff.waddr] <= s1_data;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= issue;
      last_wa_ff <= s1_ff.waddr;
      last_wd_ff <= s1_data;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         last_we_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= issue.valid;
         last_we_ff  <= wr_en;
      end
   end

   always_comb begin
      push.valid    = s1_valid_ff;
      push.out_byte = s1_data;
      push.status   = s1_ff.status;
   end

endmodule

`default_nettype wire

// ===== rtl/lz4bd_rsp_fifo.sv =====
// three-entry response queue between the history stage and the rsp channel
// depends on lz4bd_pkg, lz4bd_rsp_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "lz4_block_decompressor_unit_defines.svh"

module lz4bd_rsp_fifo (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  lz4bd_pkg::rsp_item_type                  push,
   output logic [lz4bd_pkg::RSP_CNT_W-1:0]          count,
   lz4bd_rsp_if.source                              rsp_bus
);

   lz4bd_pkg::rsp_item_type                 entry_ff [lz4bd_pkg::RSP_DEPTH];
   logic [lz4bd_pkg::RSP_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [lz4bd_pkg::RSP_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [lz4bd_pkg::RSP_CNT_W-1:0]         cnt_ff, cnt_in;
   logic                                    pop;

   localparam logic [lz4bd_pkg::RSP_PTR_W-1:0] LastPtr =
      lz4bd_pkg::RSP_PTR_W'(lz4bd_pkg::RSP_DEPTH - 1);
   localparam logic [lz4bd_pkg::RSP_CNT_W-1:0] FullCnt =
      lz4bd_pkg::RSP_CNT_W'(lz4bd_pkg::RSP_DEPTH);

   assign pop              = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid    = (cnt_ff != '0);
   assign rsp_bus.out_byte = entry_ff[rd_ptr_ff].out_byte;
   assign rsp_bus.status   = entry_ff[rd_ptr_ff].status;
   assign count            = cnt_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `LZ4BD_ASSERT_IMP(a_no_overflow, clock, reset, push.valid && !pop, cnt_ff != FullCnt, "response queue overflow")
   `LZ4BD_ASSERT_NXT(a_count_up, clock, reset, push.valid && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "queue count did not rise on push")
   `LZ4BD_ASSERT_NXT(a_count_down, clock, reset, pop && !push.valid, cnt_ff == $past(cnt_ff) - 1'b1, "queue count did not fall on pop")

endmodule

`default_nettype wire
